>>> hw/rtl/sha256_stream_hasher_core_defines.svh
// Assertion macros shared by the SHA-256 stream hasher RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/sha_pkg.sv
// Package for the SHA-256 stream hasher: constants, round table and helpers.
// No dependencies.
package sha_pkg;

    localparam int unsigned WordW = 32;

    typedef logic [WordW-1:0] t_word;

    localparam logic [7:0] PadByte = 8'h80;

    // Round constants of the compression function.
    localparam t_word RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // Initial hash value.
    localparam t_word InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic t_word ror(input t_word v, input int unsigned s);
        ror = (v >> s) | (v << (WordW - s));
    endfunction

    function automatic t_word sig0(input t_word x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

>>> hw/rtl/sha_stream_if.sv
// Valid/ready channel interfaces for the SHA-256 stream hasher.
// Depends on nothing but the clockless beat protocol.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic       no_byte;
    modport source (output valid, output data_byte, output last, output no_byte, input ready);
    modport sink (input valid, input data_byte, input last, input no_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
    modport source (output valid, output digest_word, output word_index, output digest_last,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input digest_last,
                  output ready);
endinterface

>>> hw/rtl/sha_round.sv
// One SHA-256 round plus the message schedule step; pure combinational.
// Depends on sha_pkg.
module sha_round (
    input  sha_pkg::t_word i_vars [8],
    input  sha_pkg::t_word i_w16,
    input  sha_pkg::t_word i_w15,
    input  sha_pkg::t_word i_w7,
    input  sha_pkg::t_word i_w2,
    input  sha_pkg::t_word i_blk,
    input  logic           i_use_blk,
    input  logic [5:0]     i_round,
    output sha_pkg::t_word o_vars [8],
    output sha_pkg::t_word o_wt
);
    sha_pkg::t_word wt, t1, t2, chs, mj;

    // Schedule word: block word for the first sixteen rounds, expanded after.
    assign wt = i_use_blk ? i_blk
                : i_w16 + sha_pkg::sig0(i_w15) + i_w7 + sha_pkg::sig1(i_w2);
    assign chs = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
    assign mj  = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
    assign t1  = i_vars[7] + sha_pkg::bsig1(i_vars[4]) + chs + sha_pkg::RoundConst[i_round] + wt;
    assign t2  = sha_pkg::bsig0(i_vars[0]) + mj;
    assign o_wt = wt;

    always_comb begin
        o_vars[0] = t1 + t2;
        o_vars[1] = i_vars[0];
        o_vars[2] = i_vars[1];
        o_vars[3] = i_vars[2];
        o_vars[4] = i_vars[3] + t1;
        o_vars[5] = i_vars[4];
        o_vars[6] = i_vars[5];
        o_vars[7] = i_vars[6];
    end
endmodule

>>> hw/rtl/sha256_stream_hasher_core.sv
// Top level of the SHA-256 stream hasher: byte packing, padding, rounds, digest out.
// Depends on sha_pkg, sha_stream_if, sha_round and the defines header.
//
// Use: bytes enter on the input channel one per beat, with last marking the
// final beat of a message and no_byte marking a beat without data (so an
// empty message can end). Digest words leave on the output channel, word 0
// first, with digest_last on word 7.
// A byte that does not fill a block is simply stored. A byte that fills a
// block starts a compression: a load state fills the working variables, the
// round state runs the 64 rounds and a fold state adds the result into the
// hash; the block words sit in a 16-entry memory read one word per round.
// No input is taken during a compression. A last beat pads the message byte
// by byte (9 to 72 pad bytes) with one or two of the same compressions, then
// shows 8 digest beats.
// Reset clears the control state and loads the initial hash value; no
// clearing pass is needed. A stalled receiver simply holds the current
// digest beat; no new input is taken until all eight beats are gone.
`include "sha256_stream_hasher_core_defines.svh"
module sha256_stream_hasher_core (
    input logic i_clk,
    input logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StPad  = 3'd1;
    localparam logic [2:0] StPre  = 3'd2;
    localparam logic [2:0] StRnd  = 3'd3;
    localparam logic [2:0] StFold = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [5:0]      r_pos;
    logic [5:0]      r_rnd;
    logic [63:0]     r_bits;
    logic [63:0]     r_len;
    logic            r_fin;
    logic [3:0]      r_padi;
    logic [2:0]      r_oidx;
    sha_pkg::t_word  r_hash [8];
    sha_pkg::t_word  r_vars [8];
    sha_pkg::t_word  r_sch  [16];
    sha_pkg::t_word  r_blk  [16];
    sha_pkg::t_word  r_rd;
    sha_pkg::t_word  r_part;
    sha_pkg::t_word  nv [8];
    sha_pkg::t_word  wt;

    logic       put;
    logic [7:0] put_byte;
    logic       accept;
    logic [5:0] sel_bit;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == StIdle);

    // Byte to place this cycle: input byte, or a pad byte during padding.
    always_comb begin
        put = 1'b0;
        put_byte = i_in.data_byte;
        sel_bit = 6'd0;
        if (r_state == StIdle) begin
            put = accept && !i_in.no_byte;
        end else if (r_state == StPad) begin
            put = 1'b1;
            if (r_padi == 4'd0) begin
                put_byte = sha_pkg::PadByte;
            end else if (r_padi == 4'd1) begin
                put_byte = 8'h00;
            end else begin
                sel_bit = {r_padi[2:0] - 3'd2, 3'b000};
                put_byte = 8'(r_len >> (6'd56 - sel_bit));
            end
        end
    end

    // Partial word collects bytes; the block memory takes whole words.
    always_ff @(posedge i_clk) begin
        if (put) begin
            case (r_pos[1:0])
                2'd0:    r_part <= {put_byte, 24'h0};
                2'd1:    r_part[23:16] <= put_byte;
                2'd2:    r_part[15:8] <= put_byte;
                default: r_part <= r_part;
            endcase
            if (r_pos[1:0] == 2'd3) begin
                r_blk[r_pos[5:2]] <= {r_part[31:8], put_byte};
            end
        end
        r_rd <= r_blk[(r_state == StRnd) ? 4'(r_rnd + 6'd1) : 4'd0];
    end

    sha_round u_round (
        .i_vars    (r_vars),
        .i_w16     (r_sch[r_rnd[3:0]]),
        .i_w15     (r_sch[4'(r_rnd + 6'd1)]),
        .i_w7      (r_sch[4'(r_rnd + 6'd9)]),
        .i_w2      (r_sch[4'(r_rnd + 6'd14)]),
        .i_blk     (r_rd),
        .i_use_blk (r_rnd < 6'd16),
        .i_round   (r_rnd),
        .o_vars    (nv),
        .o_wt      (wt)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            StIdle: begin
                if (accept) begin
                    if (put && r_pos == 6'd63) begin
                        n_state = StPre;
                    end else if (i_in.last) begin
                        n_state = StPad;
                    end
                end
            end
            StPad: begin
                if (r_pos == 6'd63) begin
                    n_state = StPre;
                end
            end
            StPre:  n_state = StRnd;
            StRnd:  n_state = (r_rnd == 6'd63) ? StFold : StRnd;
            StFold: begin
                if (!r_fin) begin
                    n_state = StIdle;
                end else if (r_padi == 4'd10) begin
                    n_state = StOut;
                end else begin
                    n_state = StPad;
                end
            end
            StOut: begin
                if (o_out.ready && r_oidx == 3'd7) begin
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_pos   <= 6'd0;
            r_rnd   <= 6'd0;
            r_bits  <= 64'd0;
            r_fin   <= 1'b0;
            r_padi  <= 4'd0;
            r_oidx  <= 3'd0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha_pkg::InitHash[i];
            end
        end else begin
            r_state <= n_state;
            if (put) begin
                r_pos <= r_pos + 6'd1;
            end
            // Bit count and end-of-message capture.
            if (r_state == StIdle && accept) begin
                if (!i_in.no_byte) begin
                    r_bits <= r_bits + 64'd8;
                end
                if (i_in.last) begin
                    r_fin  <= 1'b1;
                    r_padi <= 4'd0;
                    r_len  <= r_bits + (i_in.no_byte ? 64'd0 : 64'd8);
                end
            end
            // Pad step: 0x80 once, zeros until slot 56, then eight length bytes.
            if (r_state == StPad) begin
                if (r_padi == 4'd0) begin
                    r_padi <= (r_pos == 6'd55) ? 4'd2 : 4'd1;
                end else if (r_padi == 4'd1) begin
                    if (r_pos == 6'd55) r_padi <= 4'd2;
                end else begin
                    r_padi <= r_padi + 4'd1;
                end
            end
            // Rounds.
            if (r_state == StPre) begin
                r_rnd <= 6'd0;
                r_vars <= r_hash;
            end
            if (r_state == StRnd) begin
                r_vars <= nv;
                r_sch[r_rnd[3:0]] <= wt;
                r_rnd <= r_rnd + 6'd1;
            end
            if (r_state == StFold) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_vars[i];
                end
                r_oidx <= 3'd0;
            end
            // Digest beats, then reload for the next message.
            if (r_state == StOut && o_out.ready) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_fin  <= 1'b0;
                    r_bits <= 64'd0;
                    r_pos  <= 6'd0;
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= sha_pkg::InitHash[i];
                    end
                end
            end
        end
    end

    assign o_out.valid       = (r_state == StOut);
    assign o_out.digest_word = r_hash[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.digest_last = (r_oidx == 3'd7);

    `SHA_ASSERT_IMPL(a_rnd_only_in_run, i_clk, i_rst_n, r_state == StPre, r_pos == 6'd0)
    `SHA_ASSERT_NEXT(a_fold_after_last_round, i_clk, i_rst_n,
        r_state == StRnd && r_rnd == 6'd63, r_state == StFold)
    `SHA_ASSERT_IMPL(a_out_needs_fin, i_clk, i_rst_n, o_out.valid, r_fin)
    `SHA_ASSERT_IMPL(a_no_input_while_busy, i_clk, i_rst_n, r_state != StIdle, !i_in.ready)
endmodule
